// ===== hw/rtl/gn3_pkg.sv =====
// Shared types, constants and gradient select function for the 3D gradient noise block.
package gn3_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_W         = 32;
  localparam int BYTE_W          = 8;
  localparam int OUT_W           = 19;
  localparam int CORNERS         = 8;
  // pipeline stages from acceptance to the output register
  localparam int NST             = 7;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] val;
  } tbl_wr_t;

  typedef struct packed {
    logic       u_is_y;
    logic [1:0] v_axis;
    logic       neg_u;
    logic       neg_v;
  } grad_sel_t;

  // decode the low four hash bits into the gradient's axis picks and signs
  function automatic grad_sel_t grad_sel(input logic [3:0] h);
    grad_sel_t s;
    s.u_is_y = h[3];
    if (h < 4'd4) begin
      s.v_axis = AXIS_Y;
    end else if (h == 4'd12 || h == 4'd14) begin
      s.v_axis = AXIS_X;
    end else begin
      s.v_axis = AXIS_Z;
    end
    s.neg_u = h[0];
    s.neg_v = h[1];
    return s;
  endfunction

endpackage

// ===== hw/rtl/gn3_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/gn3_hash.sv =====
// Three-level permutation hash of the eight cell corners over table copies.
module gn3_hash import gn3_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              ld_in,
  input  tbl_wr_t           wr_in,
  input  logic [IW-1:0]     cell_x,
  input  logic [IW-1:0]     cell_y,
  input  logic [IW-1:0]     cell_z,
  output logic [BYTE_W-1:0] hash [CORNERS]
);

  localparam logic [IW-1:0] IDX_ONE = IW'(1);

  logic [BYTE_W-1:0] d0a, d0b, d1a_a, d1a_b, d1b_a, d1b_b;
  logic              ld1_r, ld2_r;
  tbl_wr_t           wr1_r, wr2_r;
  logic [IW-1:0]     cy1_r, cz1_r, cz2_r;
  logic [IW-1:0]     a_c, b_c;
  logic [IW-1:0]     base_c [4];

  // each table copy is written when a load item passes its read slot,
  // so items keep their order against every copy
  gn3_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_ram0 (
    .clk(clk), .we(adv & ld_in), .waddr(IW'(wr_in.idx)), .wdata(wr_in.val),
    .re(adv), .raddr_a(cell_x), .raddr_b(cell_x + IDX_ONE),
    .rdata_a(d0a), .rdata_b(d0b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld1_r <= 1'b0;
      ld2_r <= 1'b0;
    end else if (adv) begin
      ld1_r <= ld_in;
      ld2_r <= ld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr1_r <= wr_in;
      cy1_r <= cell_y;
      cz1_r <= cell_z;
      wr2_r <= wr1_r;
      cz2_r <= cz1_r;
    end
  end

  assign a_c = IW'(d0a) + cy1_r;
  assign b_c = IW'(d0b) + cy1_r;

  gn3_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_ram1a (
    .clk(clk), .we(adv & ld1_r), .waddr(IW'(wr1_r.idx)), .wdata(wr1_r.val),
    .re(adv), .raddr_a(a_c), .raddr_b(a_c + IDX_ONE),
    .rdata_a(d1a_a), .rdata_b(d1a_b)
  );

  gn3_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_ram1b (
    .clk(clk), .we(adv & ld1_r), .waddr(IW'(wr1_r.idx)), .wdata(wr1_r.val),
    .re(adv), .raddr_a(b_c), .raddr_b(b_c + IDX_ONE),
    .rdata_a(d1b_a), .rdata_b(d1b_b)
  );

  // corner order: x bit, then y bit, then z bit
  assign base_c[0] = IW'(d1a_a) + cz2_r;
  assign base_c[1] = IW'(d1b_a) + cz2_r;
  assign base_c[2] = IW'(d1a_b) + cz2_r;
  assign base_c[3] = IW'(d1b_b) + cz2_r;

  for (genvar k = 0; k < 4; k++) begin : g_ram2
    gn3_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_ram2 (
      .clk(clk), .we(adv & ld2_r), .waddr(IW'(wr2_r.idx)), .wdata(wr2_r.val),
      .re(adv), .raddr_a(base_c[k]), .raddr_b(base_c[k] + IDX_ONE),
      .rdata_a(hash[k]), .rdata_b(hash[k+4])
    );
  end

endmodule

// ===== hw/rtl/gn3_fade.sv =====
// Pipelined quintic fade curve for one axis fraction.
module gn3_fade import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic        [FRAC_BITS-1:0] t,
  output logic signed [FRAC_BITS+1:0] fade_r
);

  localparam int F = FRAC_BITS;
  localparam logic signed [F+4:0] A15 = (F+5)'(15) << F;
  localparam logic signed [F+4:0] B10 = (F+5)'(10) << F;

  logic        [F-1:0]   t1_r, t2_r;
  logic        [F:0]     c2_r, d3_r;
  logic signed [F+4:0]   b2_r, b3_r;
  logic signed [F+4:0]   a_c;
  logic signed [2*F+5:0] ta_c;
  logic        [2*F-1:0] tt_c;
  logic        [2*F:0]   ct_c;
  logic signed [2*F+6:0] db_c;

  always_comb begin
    a_c  = $signed({4'b0, t1_r, 1'b0}) + $signed({3'b0, t1_r, 2'b0}) - A15;
    ta_c = $signed({1'b0, t1_r}) * a_c;
    tt_c = t1_r * t1_r;
    ct_c = c2_r * t2_r;
    db_c = $signed({1'b0, d3_r}) * b3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= t;
      t2_r   <= t1_r;
      b2_r   <= (F+5)'((((ta_c >>> (F-1)) + 1) >>> 1)) + B10;
      c2_r   <= (F+1)'((((tt_c >> (F-1)) + 1) >> 1));
      d3_r   <= (F+1)'((((ct_c >> (F-1)) + 1) >> 1));
      b3_r   <= b2_r;
      fade_r <= (F+2)'((((db_c >>> (F-1)) + 1) >>> 1));
    end
  end

endmodule

// ===== hw/rtl/gn3_blend.sv =====
// Corner gradients and the three lerp stages down to the Q2.16 result.
module gn3_blend import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic        [BYTE_W-1:0]    hash [CORNERS],
  input  logic        [FRAC_BITS-1:0] frac_x,
  input  logic        [FRAC_BITS-1:0] frac_y,
  input  logic        [FRAC_BITS-1:0] frac_z,
  input  logic signed [FRAC_BITS+1:0] fade_u,
  input  logic signed [FRAC_BITS+1:0] fade_v,
  input  logic signed [FRAC_BITS+1:0] fade_w,
  output logic signed [OUT_W-1:0]     noise_r
);

  localparam int F  = FRAC_BITS;
  localparam int GW = F + 3;
  localparam int LW = F + 4;
  localparam int DW = F + 5;
  localparam int TW = F + 2;
  localparam int PW = 2 * F + 7;
  localparam int SH_R = (F > 16) ? F - 16 : 0;
  localparam int SH_L = (F < 16) ? 16 - F : 0;
  localparam logic signed [63:0] HALF_R =
    (SH_R > 0) ? (64'sd1 <<< ((SH_R > 0) ? SH_R - 1 : 0)) : 64'sd0;

  logic signed [GW-1:0] g_nxt [CORNERS];
  logic signed [GW-1:0] g4_r  [CORNERS];
  logic signed [LW-1:0] l5_r  [4];
  logic signed [LW-1:0] l6_r  [2];
  logic signed [TW-1:0] v5_r, w5_r, w6_r;
  logic signed [LW-1:0] r_c;
  logic signed [63:0]   conv_c;

  function automatic logic signed [LW-1:0] lerp_fx(input logic signed [TW-1:0] w,
                                                    input logic signed [LW-1:0] p,
                                                    input logic signed [LW-1:0] q);
    logic signed [DW-1:0] dif;
    logic signed [PW-1:0] prod;
    dif  = DW'(q) - DW'(p);
    prod = PW'(w) * PW'(dif);
    return p + LW'((((prod >>> (F-1)) + 1) >>> 1));
  endfunction

  // offsets toward the far corner are f - 1, which is the fraction under a set sign bit
  always_comb begin : grad_c
    logic signed [F:0] px, py, pz, uu, vv;
    grad_sel_t         s;
    for (int c = 0; c < CORNERS; c++) begin
      px = ((c & 1) != 0) ? $signed({1'b1, frac_x}) : $signed({1'b0, frac_x});
      py = ((c & 2) != 0) ? $signed({1'b1, frac_y}) : $signed({1'b0, frac_y});
      pz = ((c & 4) != 0) ? $signed({1'b1, frac_z}) : $signed({1'b0, frac_z});
      s  = grad_sel(hash[c][3:0]);
      uu = s.u_is_y ? py : px;
      case (s.v_axis)
        AXIS_X:  vv = px;
        AXIS_Y:  vv = py;
        default: vv = pz;
      endcase
      g_nxt[c] = (s.neg_u ? -GW'(uu) : GW'(uu)) + (s.neg_v ? -GW'(vv) : GW'(vv));
    end
  end

  always_comb begin
    r_c    = lerp_fx(w6_r, l6_r[0], l6_r[1]);
    conv_c = ((64'(r_c) + HALF_R) >>> SH_R) <<< SH_L;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g4_r <= g_nxt;
      for (int k = 0; k < 4; k++) begin
        l5_r[k] <= lerp_fx(fade_u, LW'(g4_r[2*k]), LW'(g4_r[2*k+1]));
      end
      v5_r    <= fade_v;
      w5_r    <= fade_w;
      l6_r[0] <= lerp_fx(v5_r, l5_r[0], l5_r[1]);
      l6_r[1] <= lerp_fx(v5_r, l5_r[2], l5_r[3]);
      w6_r    <= w5_r;
      noise_r <= OUT_W'(conv_c);
    end
  end

endmodule

// ===== hw/rtl/gradient_noise_3d.sv =====
// Evaluate items pass table lookups, then gradient, lerp and output registers.
// Throughput: one item per cycle; a full output stalls the whole pipeline.
// Load items pass the three table-lookup stages, write each table copy in turn,
// and give no result. The lookup path runs over seven two-port table copies.
// Reset clears the pipeline valid bits only; the table is undefined until loaded.
module gradient_noise_3d import gn3_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic        [BYTE_W-1:0]  in_table_index,
  input  logic        [BYTE_W-1:0]  in_table_value,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_noise_value
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int F  = FRAC_BITS;

  logic                adv;
  logic                ld_in;
  tbl_wr_t             wr_in;
  logic [NST-1:0]      ev_r;
  logic [IW-1:0]       cell_x, cell_y, cell_z;
  logic [BYTE_W-1:0]   hash [CORNERS];
  logic [F-1:0]        fr1_r [3];
  logic [F-1:0]        fr2_r [3];
  logic [F-1:0]        fr3_r [3];
  logic signed [F+1:0] fade_u, fade_v, fade_w;

  assign adv       = !ev_r[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = ev_r[NST-1];
  assign ld_in     = in_valid && (in_mode == MODE_LOAD);
  assign wr_in     = '{idx: in_table_index, val: in_table_value};

  // only the low index bits of each floor are kept
  assign cell_x = IW'(64'(in_coord_x) >>> F);
  assign cell_y = IW'(64'(in_coord_y) >>> F);
  assign cell_z = IW'(64'(in_coord_z) >>> F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
    end else if (adv) begin
      ev_r <= {ev_r[NST-2:0], in_valid && (in_mode == MODE_EVAL)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr1_r[0] <= in_coord_x[F-1:0];
      fr1_r[1] <= in_coord_y[F-1:0];
      fr1_r[2] <= in_coord_z[F-1:0];
      fr2_r    <= fr1_r;
      fr3_r    <= fr2_r;
    end
  end

  gn3_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
    .clk(clk), .rst_n(rst_n), .adv(adv), .ld_in(ld_in), .wr_in(wr_in),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z), .hash(hash)
  );

  gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk(clk), .adv(adv), .t(in_coord_x[F-1:0]), .fade_r(fade_u)
  );

  gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk(clk), .adv(adv), .t(in_coord_y[F-1:0]), .fade_r(fade_v)
  );

  gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
    .clk(clk), .adv(adv), .t(in_coord_z[F-1:0]), .fade_r(fade_w)
  );

  gn3_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk(clk), .adv(adv), .hash(hash),
    .frac_x(fr3_r[0]), .frac_y(fr3_r[1]), .frac_z(fr3_r[2]),
    .fade_u(fade_u), .fade_v(fade_v), .fade_w(fade_w),
    .noise_r(out_noise_value)
  );

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(ev_r))
    else $error("pipeline moved while stalled");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (ev_r[0] == $past(in_mode == MODE_EVAL)))
    else $error("entry valid bit does not match accepted item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_noise_value)))
    else $error("pending result lost or changed");

endmodule
